/* rtl/sinc_2d_image_interpolator_assert.svh */
// Assertion macros used by the checker file of the interpolator.
// No dependencies.
`ifndef SINC_2D_IMAGE_INTERPOLATOR_ASSERT_SVH
`define SINC_2D_IMAGE_INTERPOLATOR_ASSERT_SVH
`define SII_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SII_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/sii_pkg.sv */
// Package of the sinc interpolator: sizes, codes, state type and
// the command and status structs between controller and datapath.
package sii_pkg;
    localparam int COLS_MAX   = 256;
    localparam int ROWS_MAX   = 256;
    localparam int KERNEL_LEN = 8;
    localparam int DECIMATION = 256;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 25;
    localparam int CFG_W      = 9;
    localparam int COL_W      = $clog2(COLS_MAX);
    localparam int ROW_W      = $clog2(ROWS_MAX);
    localparam int TAP_W      = $clog2(KERNEL_LEN);
    localparam int PH_W       = $clog2(DECIMATION);
    localparam int INT_W      = COORD_W - FRAC_BITS;
    localparam int TAPS       = KERNEL_LEN * KERNEL_LEN;
    localparam int CNT_W      = $clog2(TAPS);
    localparam int ACC_W      = 54;
    localparam int HALF       = KERNEL_LEN / 2;

    typedef enum logic [1:0] {
        OP_WRITE_PIXEL = 2'd0,
        OP_WRITE_COEF  = 2'd1,
        OP_INTERP      = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    localparam logic [0:0] REG_IMAGE_COLS = 1'b0;
    localparam logic [0:0] REG_IMAGE_ROWS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic setup;
        logic issue;
        logic clear_acc;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_bounds;
        logic last_tap;
        logic pipe_empty;
    } status_t;
endpackage

/* rtl/sii_if.sv */
// Valid/ready channel interfaces of the sinc interpolator.
// Depends on sii_pkg.
interface sii_in_if import sii_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [7:0]           pixel_row;
    logic [7:0]           pixel_col;
    logic signed [15:0]   pixel_re;
    logic signed [15:0]   pixel_im;
    logic [7:0]           coef_phase;
    logic [2:0]           coef_tap;
    logic signed [15:0]   coef_value;
    logic signed [24:0]   x_coord;
    logic signed [24:0]   y_coord;
    modport source (output valid, operation, pixel_row, pixel_col, pixel_re, pixel_im,
                    coef_phase, coef_tap, coef_value, x_coord, y_coord, input ready);
    modport sink (input valid, operation, pixel_row, pixel_col, pixel_re, pixel_im,
                  coef_phase, coef_tap, coef_value, x_coord, y_coord, output ready);
endinterface

interface sii_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] result_re;
    logic signed [15:0] result_im;
    logic               out_of_bounds;
    logic               saturated;
    modport source (output valid, result_re, result_im, out_of_bounds, saturated,
                    input ready);
    modport sink (input valid, result_re, result_im, out_of_bounds, saturated,
                  output ready);
endinterface

interface sii_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [8:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/sii_ctrl.sv */
// Controller state machine of the sinc interpolator.
// Depends on sii_pkg; drives the datapath through cmd_t.
module sii_ctrl
    import sii_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    out_free,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_LOAD;
            ST_LOAD:   state_next = status.out_bounds ? ST_OUTPUT : ST_RUN;
            ST_RUN:    if (status.last_tap) state_next = ST_DRAIN;
            ST_DRAIN:  if (status.pipe_empty) state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUTPUT;
            ST_OUTPUT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                cmd.setup = start;
            end
            ST_LOAD:   cmd.clear_acc = 1'b1;
            ST_RUN:    cmd.issue = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: cmd.finish = 1'b1;
            ST_OUTPUT: cmd.load_out = out_free;
            default:   ;
        endcase
    end
endmodule

/* rtl/sii_datapath.sv */
// Datapath of the sinc interpolator: image and kernel memories, coordinate
// split, pipelined complex multiply-accumulate, rounding and saturation. Uses sii_pkg.
module sii_datapath
    import sii_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic [1:0]           operation,
    input  logic [7:0]           pixel_row,
    input  logic [7:0]           pixel_col,
    input  logic signed [15:0]   pixel_re,
    input  logic signed [15:0]   pixel_im,
    input  logic [7:0]           coef_phase,
    input  logic [2:0]           coef_tap,
    input  logic signed [15:0]   coef_value,
    input  logic signed [24:0]   x_coord,
    input  logic signed [24:0]   y_coord,
    input  logic [CFG_W-1:0]     cols_cfg,
    input  logic [CFG_W-1:0]     rows_cfg,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic signed [15:0]   res_re,
    output logic signed [15:0]   res_im,
    output logic                 res_oob,
    output logic                 res_sat
);
    logic [31:0] image_mem [COLS_MAX*ROWS_MAX];
    logic signed [15:0] kx_mem [DECIMATION*KERNEL_LEN];
    logic signed [15:0] ky_mem [DECIMATION*KERNEL_LEN];

    logic signed [INT_W-1:0] ix_reg, iy_reg;
    logic [PH_W-1:0] phx_reg, phy_reg;
    logic oob_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic in1_reg;
    logic [31:0] pix_reg;
    logic signed [15:0] kx_reg, ky_reg;
    logic signed [31:0] kk_reg;
    logic signed [15:0] pr_reg, pi_reg;
    logic signed [47:0] mr_reg, mi_reg;
    logic signed [ACC_W-1:0] acc_re_reg, acc_im_reg;
    logic signed [15:0] res_re_reg, res_im_reg;
    logic res_sat_reg;

    logic signed [INT_W-1:0] ix_in, iy_in;
    logic signed [INT_W+1:0] cols_s, rows_s;
    logic oob_now;
    logic [TAP_W-1:0] ti, tj;
    logic signed [INT_W+1:0] rr, cc;
    logic in_win;
    logic signed [ACC_W-1:0] rnd_re, rnd_im;
    logic signed [ACC_W-29:0] sh_re, sh_im;
    logic signed [15:0] sat_re_v, sat_im_v;
    logic sat_re, sat_im;

    function automatic logic [PH_W-1:0] phase_of(input logic [FRAC_BITS-1:0] f);
        logic [FRAC_BITS+PH_W-1:0] p;
        p = ({{PH_W{1'b0}}, f} * (FRAC_BITS+PH_W)'(DECIMATION)) >> FRAC_BITS;
        return (p > (FRAC_BITS+PH_W)'(DECIMATION-1)) ? PH_W'(DECIMATION-1) : p[PH_W-1:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-29:0] v,
                                                 output logic f);
        f = 1'b0;
        if (v > 32767)
        begin
            f = 1'b1;
            return 16'sd32767;
        end
        if (v < -32768)
        begin
            f = 1'b1;
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    assign ix_in = x_coord[COORD_W-1:FRAC_BITS];
    assign iy_in = y_coord[COORD_W-1:FRAC_BITS];
    assign cols_s = (cols_cfg > CFG_W'(COLS_MAX)) ? (INT_W+2)'(COLS_MAX)
                                                  : (INT_W+2)'(cols_cfg);
    assign rows_s = (rows_cfg > CFG_W'(ROWS_MAX)) ? (INT_W+2)'(ROWS_MAX)
                                                  : (INT_W+2)'(rows_cfg);
    assign oob_now = ((INT_W+2)'(ix_reg) < (INT_W+2)'(HALF-1))
                  || ((INT_W+2)'(ix_reg) > cols_s - (INT_W+2)'(HALF+1))
                  || ((INT_W+2)'(iy_reg) < (INT_W+2)'(HALF-1))
                  || ((INT_W+2)'(iy_reg) > rows_s - (INT_W+2)'(HALF+1));

    always_ff @(posedge clk)
    begin
        if (in_fire && operation == OP_WRITE_PIXEL)
            image_mem[{pixel_row[ROW_W-1:0], pixel_col[COL_W-1:0]}] <= {pixel_im, pixel_re};
        if (in_fire && operation == OP_WRITE_COEF)
        begin
            kx_mem[{coef_phase[PH_W-1:0], coef_tap[TAP_W-1:0]}] <= coef_value;
            ky_mem[{coef_phase[PH_W-1:0], coef_tap[TAP_W-1:0]}] <= coef_value;
        end
        if (cmd.setup)
        begin
            ix_reg  <= ix_in;
            iy_reg  <= iy_in;
            phx_reg <= phase_of(x_coord[FRAC_BITS-1:0]);
            phy_reg <= phase_of(y_coord[FRAC_BITS-1:0]);
        end
        if (cmd.clear_acc)
            oob_reg <= oob_now;
    end

    assign ti = cnt_reg[CNT_W-1:TAP_W];
    assign tj = cnt_reg[TAP_W-1:0];
    assign rr = (INT_W+2)'(iy_reg) + (INT_W+2)'(HALF) - (INT_W+2)'(ti);
    assign cc = (INT_W+2)'(ix_reg) + (INT_W+2)'(HALF) - (INT_W+2)'(tj);
    assign in_win = (rr >= 0) && (cc >= 0) && (rr < (INT_W+2)'(ROWS_MAX))
                 && (cc < (INT_W+2)'(COLS_MAX));

    always_ff @(posedge clk)
    begin
        pix_reg <= image_mem[{rr[ROW_W-1:0], cc[COL_W-1:0]}];
        kx_reg  <= kx_mem[{phx_reg, tj}];
        ky_reg  <= ky_mem[{phy_reg, ti}];
        in1_reg <= in_win;
        kk_reg  <= kx_reg * ky_reg;
        pr_reg  <= in1_reg ? pix_reg[15:0] : 16'sd0;
        pi_reg  <= in1_reg ? pix_reg[31:16] : 16'sd0;
        mr_reg  <= pr_reg * kk_reg;
        mi_reg  <= pi_reg * kk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cmd.issue ? cnt_reg + 1'b1 : '0;
            v1_reg  <= cmd.issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_acc)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(mr_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(mi_reg);
        end
    end

    assign rnd_re = acc_re_reg + (ACC_W'(1) <<< 27);
    assign rnd_im = acc_im_reg + (ACC_W'(1) <<< 27);
    assign sh_re = rnd_re[ACC_W-1:28];
    assign sh_im = rnd_im[ACC_W-1:28];

    always_comb
    begin
        sat_re_v = sat16(sh_re, sat_re);
        sat_im_v = sat16(sh_im, sat_im);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_re_reg  <= sat_re_v;
            res_im_reg  <= sat_im_v;
            res_sat_reg <= sat_re | sat_im;
        end
        else if (cmd.clear_acc)
        begin
            res_re_reg  <= '0;
            res_im_reg  <= '0;
            res_sat_reg <= 1'b0;
        end
    end

    assign status.out_bounds = oob_now;
    assign status.last_tap = cmd.issue && (cnt_reg == CNT_W'(TAPS-1));
    assign status.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
    assign res_re  = res_re_reg;
    assign res_im  = res_im_reg;
    assign res_oob = oob_reg;
    assign res_sat = res_sat_reg;
endmodule

/* rtl/sinc_2d_image_interpolator.sv */
// Top level of the separable windowed-sinc 2D interpolator.
// Depends on sii_pkg, the channel interfaces, sii_ctrl and sii_datapath.
//
// Usage: items arrive on the in channel. Pixel and kernel writes give no
// result. An interpolate item walks the 8 by 8 window through one shared
// complex multiply-accumulate, one pixel read per cycle from the image
// memory, then rounds and saturates.
// An interpolate in bounds passes the setup step, the 64 taps, the drain,
// the finish step and the output load; one out of bounds goes from setup
// and the bounds check straight to the output load. One interpolate is in
// flight at a time: no new item is taken until its result is loaded.
// The result sits in an output register; a stalled receiver holds it there.
// The next item is still taken, but a following interpolate waits with its
// result inside the block, taking no input, until that transfer completes.
// Configuration writes on cfg are taken in any cycle. Reset sets both
// size registers to 256 and empties the output; memories are undefined
// until written.
module sinc_2d_image_interpolator
    import sii_pkg::*;
(
    input logic clk,
    input logic rst_n,
    sii_in_if.sink   in_ch,
    sii_out_if.source out_ch,
    sii_cfg_if.sink  cfg
);
    logic [CFG_W-1:0] cols_reg, rows_reg;
    cmd_t cmd;
    status_t status;
    logic busy, start, in_fire, out_valid_reg;
    logic signed [15:0] re_w, im_w, re_reg, im_reg;
    logic oob_w, sat_w, oob_reg, sat_reg;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_W'(256);
            rows_reg <= CFG_W'(256);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_COLS: cols_reg <= cfg.data;
                REG_IMAGE_ROWS: rows_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = !busy;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign start = in_fire && (in_ch.operation == OP_INTERP);

    sii_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start),
        .out_free(!out_valid_reg || out_ch.ready),
        .status(status), .cmd(cmd), .busy(busy)
    );

    sii_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .operation(in_ch.operation), .pixel_row(in_ch.pixel_row),
        .pixel_col(in_ch.pixel_col), .pixel_re(in_ch.pixel_re),
        .pixel_im(in_ch.pixel_im), .coef_phase(in_ch.coef_phase),
        .coef_tap(in_ch.coef_tap), .coef_value(in_ch.coef_value),
        .x_coord(in_ch.x_coord), .y_coord(in_ch.y_coord),
        .cols_cfg(cols_reg), .rows_cfg(rows_reg), .cmd(cmd), .status(status),
        .res_re(re_w), .res_im(im_w), .res_oob(oob_w), .res_sat(sat_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            re_reg  <= oob_w ? 16'sd0 : re_w;
            im_reg  <= oob_w ? 16'sd0 : im_w;
            oob_reg <= oob_w;
            sat_reg <= oob_w ? 1'b0 : sat_w;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.result_re = re_reg;
    assign out_ch.result_im = im_reg;
    assign out_ch.out_of_bounds = oob_reg;
    assign out_ch.saturated = sat_reg;
endmodule

/* rtl/sii_checker.sv */
// Port-level checker of the sinc interpolator, bound to the top level.
// Depends on the assertion macro header.
`include "sinc_2d_image_interpolator_assert.svh"
module sii_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        oob,
    input logic        sat,
    input logic [15:0] re,
    input logic [15:0] im
);
    `SII_ASSERT_IMPL(a_oob_zero, clk, rst_n, out_valid && oob, re == 16'd0 && im == 16'd0 && !sat, "out-of-bounds result not zero")
    `SII_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(re) && $stable(im), "stalled result changed")
    `SII_ASSERT_IMPL(a_sat_val, clk, rst_n, out_valid && sat, re == 16'h7fff || re == 16'h8000 || im == 16'h7fff || im == 16'h8000, "saturation flag without clipped value")
endmodule

bind sinc_2d_image_interpolator sii_checker u_sii_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .oob(out_ch.out_of_bounds), .sat(out_ch.saturated),
    .re(out_ch.result_re), .im(out_ch.result_im)
);
